// ----- rtl/core/kch_pkg.sv -----
// Package of the k-mer count histogram core: widths, codes, command and
// status structs, base decoding and code mask helpers. No dependencies.
package kch_pkg;

    localparam int MAX_K       = 8;
    localparam int CODE_W      = 16;
    localparam int TABLE_DEPTH = 1 << CODE_W;
    localparam int CNT_W       = 32;
    localparam int RUN_W       = 4;
    localparam int POS_W       = 9;
    localparam int K_W         = 4;
    localparam int START_W     = 8;
    localparam int CFG_W       = 8;

    localparam logic [RUN_W-1:0] RUN_MAX   = 4'd15;
    localparam logic [POS_W-1:0] POS_MAX   = 9'd511;
    localparam logic [CNT_W-1:0] SAT_COUNT = 32'hFFFF_FFFF;

    localparam logic [K_W-1:0]     KMER_LEN_RESET    = 4'd8;
    localparam logic               WINDOW_MODE_RESET = 1'b0;
    localparam logic [START_W-1:0] START_POS_RESET   = 8'd2;

    typedef enum logic [1:0] {
        OP_BASE       = 2'd0,
        OP_NEW_SEQ    = 2'd1,
        OP_QUERY      = 2'd2,
        OP_READ_CLEAR = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        CFG_KMER_LEN    = 2'd0,
        CFG_WINDOW_MODE = 2'd1,
        CFG_START_POS   = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_COMMIT
    } state_t;

    typedef struct packed {
        logic clr_wr;
        logic accept;
        logic mem_rd;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic out_free;
    } ctrl_status_t;

    localparam logic [7:0] CH_A_UP = 8'h41;
    localparam logic [7:0] CH_C_UP = 8'h43;
    localparam logic [7:0] CH_G_UP = 8'h47;
    localparam logic [7:0] CH_T_UP = 8'h54;
    localparam logic [7:0] CH_A_LO = 8'h61;
    localparam logic [7:0] CH_C_LO = 8'h63;
    localparam logic [7:0] CH_G_LO = 8'h67;
    localparam logic [7:0] CH_T_LO = 8'h74;

    // bit 2 flags a valid nucleotide, bits 1:0 carry its code
    function automatic logic [2:0] decode_base(input logic [7:0] ch);
        logic [2:0] res;
        case (ch)
            CH_A_UP, CH_A_LO: res = 3'b100;
            CH_C_UP, CH_C_LO: res = 3'b101;
            CH_G_UP, CH_G_LO: res = 3'b110;
            CH_T_UP, CH_T_LO: res = 3'b111;
            default:          res = 3'b000;
        endcase
        return res;
    endfunction

    function automatic logic [K_W-1:0] effective_k(input logic [K_W-1:0] k);
        logic [K_W-1:0] res;
        if (k == '0)
            res = K_W'(1);
        else if (k > K_W'(MAX_K))
            res = K_W'(MAX_K);
        else
            res = k;
        return res;
    endfunction

    function automatic logic [CODE_W-1:0] code_mask(input logic [K_W-1:0] k);
        logic [4:0] sh;
        sh = 5'(CODE_W) - {k, 1'b0};
        return {CODE_W{1'b1}} >> sh;
    endfunction

endpackage

// ----- rtl/core/kch_ctrl.sv -----
// Controller state machine of the k-mer count histogram core.
// Depends on kch_pkg for the state type and the command and status structs.
module kch_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  kch_pkg::ctrl_status_t status,
    output kch_pkg::ctrl_cmd_t    cmd
);
    import kch_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (status.clr_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                    state_next = ST_READ;
            end
            ST_READ:
                state_next = ST_COMMIT;
            ST_COMMIT:
            begin
                if (status.out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_CLEAR;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_CLEAR:
                cmd.clr_wr = 1'b1;
            ST_IDLE:
            begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            ST_READ:
                cmd.mem_rd = 1'b1;
            ST_COMMIT:
                cmd.commit = status.out_free;
            default:
                cmd = '0;
        endcase
    end

endmodule

// ----- rtl/core/kch_datapath.sv -----
// Datapath of the k-mer count histogram core: configuration, window state,
// count table memory, saturating update and output register. Uses kch_pkg.
module kch_datapath (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [1:0]                       cfg_index,
    input  logic [kch_pkg::CFG_W-1:0]        cfg_data,
    input  logic [1:0]                       in_op,
    input  logic [7:0]                       in_base_char,
    input  logic [kch_pkg::CODE_W-1:0]       in_query_code,
    input  kch_pkg::ctrl_cmd_t               cmd,
    output kch_pkg::ctrl_status_t            status,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic                             out_counted,
    output logic [kch_pkg::CODE_W-1:0]       out_kmer_code,
    output logic [kch_pkg::CNT_W-1:0]        out_count,
    output logic [kch_pkg::CNT_W-1:0]        out_total
);
    import kch_pkg::*;

    logic [K_W-1:0]     kmer_len_reg;
    logic               window_mode_reg;
    logic [START_W-1:0] start_pos_reg;

    logic [CODE_W-1:0]  window_code_reg, window_code_next;
    logic [RUN_W-1:0]   valid_run_reg, valid_run_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [CNT_W-1:0]   total_reg, total_next;

    op_t                op_reg;
    logic [CODE_W-1:0]  code_reg, code_next;
    logic               take_reg, take_next;
    logic [CODE_W-1:0]  clr_addr_reg;
    logic [CNT_W-1:0]   rd_data_reg;

    logic               m_valid_reg;
    logic               out_counted_reg;
    logic [CODE_W-1:0]  out_code_reg;
    logic [CNT_W-1:0]   out_count_reg, count_next;
    logic [CNT_W-1:0]   out_total_reg;

    logic [CNT_W-1:0]   mem [TABLE_DEPTH];
    logic               mem_we;
    logic [CODE_W-1:0]  mem_waddr;
    logic [CNT_W-1:0]   mem_wdata;
    logic [CNT_W-1:0]   inc_data;

    logic [2:0]         dec;
    logic [K_W-1:0]     k_eff;
    logic [POS_W-1:0]   target_pos;
    logic               pos_hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kmer_len_reg    <= KMER_LEN_RESET;
            window_mode_reg <= WINDOW_MODE_RESET;
            start_pos_reg   <= START_POS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_KMER_LEN:    kmer_len_reg    <= cfg_data[K_W-1:0];
                CFG_WINDOW_MODE: window_mode_reg <= cfg_data[0];
                CFG_START_POS:   start_pos_reg   <= cfg_data[START_W-1:0];
                default:         kmer_len_reg    <= kmer_len_reg;
            endcase
        end
    end

    always_comb
    begin
        dec        = decode_base(in_base_char);
        k_eff      = effective_k(kmer_len_reg);
        target_pos = POS_W'(start_pos_reg) + POS_W'(k_eff) - POS_W'(1);

        window_code_next = window_code_reg;
        valid_run_next   = valid_run_reg;
        pos_next         = pos_reg;
        code_next        = '0;
        take_next        = 1'b0;
        pos_hit          = 1'b0;

        case (op_t'(in_op))
            OP_BASE:
            begin
                if (pos_reg != POS_MAX)
                    pos_next = pos_reg + POS_W'(1);
                if (!dec[2])
                    valid_run_next = '0;
                else
                begin
                    window_code_next = {window_code_reg[CODE_W-3:0], dec[1:0]};
                    if (valid_run_reg != RUN_MAX)
                        valid_run_next = valid_run_reg + RUN_W'(1);
                    pos_hit = (start_pos_reg != '0) && (pos_next == target_pos);
                    if (valid_run_next >= k_eff)
                        take_next = !window_mode_reg || pos_hit;
                end
                if (take_next)
                    code_next = window_code_next & code_mask(k_eff);
            end
            OP_NEW_SEQ:
            begin
                pos_next         = '0;
                valid_run_next   = '0;
                window_code_next = '0;
            end
            OP_QUERY, OP_READ_CLEAR:
                code_next = in_query_code;
            default:
                code_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_code_reg <= '0;
            valid_run_reg   <= '0;
            pos_reg         <= '0;
        end
        else if (cmd.accept)
        begin
            window_code_reg <= window_code_next;
            valid_run_reg   <= valid_run_next;
            pos_reg         <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg   <= op_t'(in_op);
            code_reg <= code_next;
            take_reg <= take_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_addr_reg <= '0;
        else if (cmd.clr_wr)
            clr_addr_reg <= clr_addr_reg + CODE_W'(1);
    end

    assign status.clr_last = (clr_addr_reg == {CODE_W{1'b1}});
    assign status.out_free = !m_valid_reg || m_tready;

    assign inc_data = (rd_data_reg == SAT_COUNT) ? rd_data_reg : rd_data_reg + CNT_W'(1);

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = code_reg;
        mem_wdata = '0;
        if (cmd.clr_wr)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
        end
        else if (cmd.commit)
        begin
            if (take_reg)
            begin
                mem_we    = 1'b1;
                mem_wdata = inc_data;
            end
            else if (op_reg == OP_READ_CLEAR)
                mem_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (cmd.mem_rd)
            rd_data_reg <= mem[code_reg];
    end

    always_comb
    begin
        total_next = total_reg;
        count_next = '0;
        if (take_reg)
        begin
            count_next = inc_data;
            if (total_reg != SAT_COUNT)
                total_next = total_reg + CNT_W'(1);
        end
        else if (op_reg == OP_QUERY || op_reg == OP_READ_CLEAR)
            count_next = rd_data_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.commit)
            begin
                total_reg   <= total_next;
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
                m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_counted_reg <= take_reg;
            out_code_reg    <= code_reg;
            out_count_reg   <= count_next;
            out_total_reg   <= total_next;
        end
    end

    assign m_tvalid      = m_valid_reg;
    assign out_counted   = out_counted_reg;
    assign out_kmer_code = out_code_reg;
    assign out_count     = out_count_reg;
    assign out_total     = out_total_reg;

endmodule

// ----- rtl/core/kmer_count_histogram_core.sv -----
// Top level of the k-mer count histogram core: stream ports, configuration
// port, controller and datapath. Depends on kch_pkg, kch_ctrl, kch_datapath.
//
// Each transaction passes through three steps: accept, count table read,
// then the table update together with the load of the output register.
// The count table has a registered read, hence the separate read step. The
// update step is held while the output register still holds a result that
// has not been taken. The result waits in the output register, so the next
// transaction can be accepted before that result is taken. After reset the
// 65536-entry count table is zeroed one entry per cycle; s_tready stays low
// until it is done. Configuration writes are taken at any time.
module kmer_count_histogram_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [1:0]                  cfg_index,
    input  logic [kch_pkg::CFG_W-1:0]   cfg_data,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [23:0]                 s_tdata,   // base_char[7:0], query_code[23:8]
    input  logic [1:0]                  s_tuser,   // op[1:0]
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [79:0]                 m_tdata,   // kmer_code[15:0], count[47:16],
                                                   // total_counted[79:48]
    output logic                        m_tuser    // counted
);
    import kch_pkg::*;

    ctrl_cmd_t         cmd;
    ctrl_status_t      status;
    logic [CODE_W-1:0] out_kmer_code;
    logic [CNT_W-1:0]  out_count;
    logic [CNT_W-1:0]  out_total;

    kch_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    kch_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_op         (s_tuser),
        .in_base_char  (s_tdata[7:0]),
        .in_query_code (s_tdata[23:8]),
        .cmd           (cmd),
        .status        (status),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .out_counted   (m_tuser),
        .out_kmer_code (out_kmer_code),
        .out_count     (out_count),
        .out_total     (out_total)
    );

    assign m_tdata = {out_total, out_count, out_kmer_code};

endmodule

// ----- rtl/core/kch_checker.sv -----
// Port-level checker of the k-mer count histogram core and its bind to the
// top level. Depends on kmer_count_histogram_core.
module kch_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [79:0] m_tdata,
    input logic        m_tuser
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("output transaction changed while stalled");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while a transaction is in flight");

    a_counted_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata[47:16] != 32'd0 && m_tdata[79:48] != 32'd0))
        else $error("counted result with zero count or total");

    a_total_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready) ##1 m_tvalid |-> m_tdata[79:48] >= $past(m_tdata[79:48]))
        else $error("total decreased between results");

endmodule

bind kmer_count_histogram_core kch_checker u_kch_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ----- tb/tb.sv -----
// Self-checking testbench for kmer_count_histogram_core: streams bases, sequence
// breaks, queries and read-and-clear commands through several register settings.
// Depends on kch_pkg and the core RTL; predicts every result from its own count table.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import kch_pkg::*;

    localparam int STALL_LIMIT = 300000;

    typedef struct {
        op_t         op;
        logic [7:0]  ch;
        logic [15:0] qcode;
    } seq_item_t;

    typedef struct {
        logic        counted;
        logic [15:0] code;
        logic [31:0] cnt;
        logic [31:0] total;
    } hist_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [7:0]  cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;
    logic        m_tuser;

    kmer_count_histogram_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #10 clk = ~clk;

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    // predicted block state
    logic [31:0] kmer_hist [0:65535];
    logic [15:0] shift_code = '0;
    logic [3:0]  run_len = '0;
    logic [8:0]  seq_pos = '0;
    logic [31:0] total_kmers = '0;
    logic [3:0]  cfg_k = KMER_LEN_RESET;
    logic        cfg_mode = WINDOW_MODE_RESET;
    logic [7:0]  cfg_start = START_POS_RESET;

    seq_item_t    pending_items_q[$];
    hist_result_t result_due_q[$];
    logic [15:0]  hit_codes_q[$];
    seq_item_t    cur_item;

    logic drv_busy = 1'b0;
    bit   calm = 1'b0;
    int   src_gap = 0;
    int   sink_stall = 0;
    int   idle_cycles = 0;
    int   fail_count = 0;
    int   queued_count = 0;
    int   items_accepted = 0;
    int   results_checked = 0;
    int   windows_counted = 0;
    int   phase_count = 1;

    function automatic int unsigned eff_len();
        if (cfg_k == 4'd0)
            return 1;
        if (cfg_k > 4'(MAX_K))
            return MAX_K;
        return cfg_k;
    endfunction

    function automatic logic [15:0] len_mask(input int unsigned k);
        logic [31:0] m;
        m = (32'h1 << (2 * k)) - 32'h1;
        return m[15:0];
    endfunction

    function automatic logic [2:0] nt_code(input logic [7:0] c);
        case (c)
            CH_A_UP, CH_A_LO: return 3'b100;
            CH_C_UP, CH_C_LO: return 3'b101;
            CH_G_UP, CH_G_LO: return 3'b110;
            CH_T_UP, CH_T_LO: return 3'b111;
            default:          return 3'b000;
        endcase
    endfunction

    task automatic histogram_step(input seq_item_t it);
        hist_result_t r;
        logic [2:0]   nt;
        int unsigned  k;
        logic         take;
        r.counted = 1'b0;
        r.code = '0;
        r.cnt = '0;
        k = eff_len();
        case (it.op)
            OP_BASE:
            begin
                nt = nt_code(it.ch);
                if (seq_pos != POS_MAX)
                    seq_pos = seq_pos + 9'd1;
                if (!nt[2])
                    run_len = '0;
                else
                begin
                    shift_code = {shift_code[13:0], nt[1:0]};
                    if (run_len != RUN_MAX)
                        run_len = run_len + 4'd1;
                    if (run_len >= k)
                    begin
                        if (cfg_mode)
                            take = (cfg_start != 8'd0) && (seq_pos == cfg_start + k - 1);
                        else
                            take = 1'b1;
                        if (take)
                        begin
                            r.code = shift_code & len_mask(k);
                            if (kmer_hist[r.code] != SAT_COUNT)
                                kmer_hist[r.code] = kmer_hist[r.code] + 32'd1;
                            if (total_kmers != SAT_COUNT)
                                total_kmers = total_kmers + 32'd1;
                            r.cnt = kmer_hist[r.code];
                            r.counted = 1'b1;
                            windows_counted++;
                            hit_codes_q = {hit_codes_q, r.code};
                            if (hit_codes_q.size() > 64)
                                void'(hit_codes_q.pop_front());
                        end
                    end
                end
            end
            OP_NEW_SEQ:
            begin
                seq_pos = '0;
                run_len = '0;
                shift_code = '0;
            end
            default:
            begin
                r.code = it.qcode;
                r.cnt = kmer_hist[it.qcode];
                if (it.op == OP_READ_CLEAR)
                    kmer_hist[it.qcode] = '0;
            end
        endcase
        r.total = total_kmers;
        result_due_q = {result_due_q, r};
    endtask

    task automatic push_item(input op_t op, input logic [7:0] ch, input logic [15:0] q);
        seq_item_t it;
        it.op = op;
        it.ch = ch;
        it.qcode = q;
        pending_items_q = {pending_items_q, it};
        queued_count++;
    endtask

    function automatic logic [7:0] pick_base();
        case ($urandom_range(0, 7))
            0:       return CH_A_UP;
            1:       return CH_C_UP;
            2:       return CH_G_UP;
            3:       return CH_T_UP;
            4:       return CH_A_LO;
            5:       return CH_C_LO;
            6:       return CH_G_LO;
            default: return CH_T_LO;
        endcase
    endfunction

    function automatic logic [7:0] pick_junk();
        logic [7:0] c;
        logic [2:0] nt;
        c = 8'($urandom);
        nt = nt_code(c);
        while (nt[2])
        begin
            c = 8'($urandom);
            nt = nt_code(c);
        end
        return c;
    endfunction

    function automatic logic [15:0] pick_query();
        int unsigned r;
        r = $urandom_range(0, 2);
        if (r == 0 && hit_codes_q.size() > 0)
            return hit_codes_q[$urandom_range(0, hit_codes_q.size() - 1)];
        if (r == 1)
            return 16'($urandom) & len_mask(eff_len());
        return 16'($urandom);
    endfunction

    task automatic add_sequence(input int len, input int junk_pct);
        push_item(OP_NEW_SEQ, 8'($urandom), 16'($urandom));
        for (int i = 0; i < len; i++)
            push_item(OP_BASE, ($urandom_range(0, 99) < junk_pct) ? pick_junk() : pick_base(),
                      16'($urandom));
    endtask

    task automatic add_phase(input int n);
        int target;
        int unsigned len;
        int unsigned k;
        int unsigned sp;
        int junk;
        target = queued_count + n;
        k = eff_len();
        sp = cfg_start;
        while (queued_count < target)
        begin
            case ($urandom_range(0, 9))
                0:       push_item(OP_QUERY, 8'($urandom), pick_query());
                1:       push_item(OP_READ_CLEAR, 8'($urandom), pick_query());
                default:
                begin
                    junk = ($urandom_range(0, 3) == 0) ? 20 : 2;
                    if (!cfg_mode)
                        len = $urandom_range(1, 40);
                    else if (sp == 0)
                        len = $urandom_range(1, 12);
                    else
                        len = $urandom_range(sp + k - 2, sp + k + 3);
                    add_sequence(len, junk);
                end
            endcase
        end
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [7:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        case (idx)
            CFG_KMER_LEN:
            begin
                cfg_data <= {4'($urandom), val[3:0]};
                cfg_k = val[3:0];
            end
            CFG_WINDOW_MODE:
            begin
                cfg_data <= {7'($urandom), val[0]};
                cfg_mode = val[0];
            end
            default:
            begin
                cfg_data <= val;
                cfg_start = val;
            end
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_items_q.size() != 0 || drv_busy || result_due_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic run_config(input logic [3:0] k, input logic mode, input logic [7:0] sp);
        wait_idle();
        write_reg(CFG_KMER_LEN, {4'd0, k});
        write_reg(CFG_WINDOW_MODE, {7'd0, mode});
        write_reg(CFG_START_POS, sp);
        phase_count++;
    endtask

    initial
    begin
        for (int i = 0; i < 65536; i++)
            kmer_hist[i] = '0;

        // reset settings: k 8, sliding
        push_item(OP_QUERY, 8'h00, 16'h0000);
        push_item(OP_QUERY, 8'hFF, 16'hFFFF);
        push_item(OP_NEW_SEQ, 8'h00, 16'h0000);
        push_item(OP_BASE, CH_A_UP, 16'hFFFF);
        push_item(OP_BASE, CH_C_UP, 16'h0000);
        push_item(OP_BASE, CH_G_UP, 16'h0000);
        push_item(OP_BASE, CH_T_UP, 16'h0000);
        push_item(OP_BASE, CH_A_LO, 16'h0000);
        push_item(OP_BASE, CH_C_LO, 16'h0000);
        push_item(OP_BASE, CH_G_LO, 16'h0000);
        push_item(OP_BASE, CH_T_LO, 16'h0000);
        push_item(OP_BASE, CH_A_UP, 16'h0000);
        push_item(OP_BASE, 8'h4E, 16'h0000);
        push_item(OP_BASE, CH_T_UP, 16'h0000);
        push_item(OP_BASE, 8'h00, 16'h0000);
        push_item(OP_BASE, 8'hFF, 16'hFFFF);
        push_item(OP_NEW_SEQ, 8'hFF, 16'hFFFF);
        push_item(OP_QUERY, 8'h00, 16'h1B1B);
        push_item(OP_READ_CLEAR, 8'h00, 16'h1B1B);
        push_item(OP_QUERY, 8'h00, 16'h1B1B);
        push_item(OP_READ_CLEAR, 8'hFF, 16'hFFFF);

        run_config(4'd1, 1'b0, 8'd2);
        add_phase(200);
        run_config(4'd0, 1'b1, 8'd1);
        add_phase(100);
        run_config(4'd15, 1'b0, 8'd9);
        add_phase(220);
        run_config(4'd3, 1'b1, 8'd0);
        add_phase(100);

        // late start window and position saturation in one long sequence
        run_config(4'd8, 1'b1, 8'd255);
        add_sequence(530, 0);
        for (int i = 0; i < 15; i++)
            push_item(($urandom_range(0, 1) == 0) ? OP_QUERY : OP_READ_CLEAR,
                      8'($urandom), pick_query());

        run_config(4'd4, 1'b1, 8'd5);
        add_phase(200);
        run_config(4'd2, 1'b0, 8'd37);
        add_phase(200);
        run_config(4'd5, 1'b0, 8'd200);
        calm = 1'b1;
        add_phase(180);

        wait_idle();
        repeat (12) @(posedge clk);
        if (result_due_q.size() != 0)
        begin
            $error("%0d results never arrived", result_due_q.size());
            fail_count++;
        end
        $display("run covered %0d transactions over %0d register settings", items_accepted,
                 phase_count);
        $display("%0d results checked, %0d k-mer windows counted", results_checked,
                 windows_counted);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else
        begin
            if (s_tvalid && s_tready)
            begin
                histogram_step(cur_item);
                items_accepted++;
                drv_busy = 1'b0;
            end
            if (!drv_busy)
            begin
                if (src_gap != 0)
                begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_items_q.size() != 0)
                begin
                    cur_item = pending_items_q.pop_front();
                    drv_busy = 1'b1;
                    s_tvalid <= 1'b1;
                    s_tdata <= {cur_item.qcode, cur_item.ch};
                    s_tuser <= cur_item.op;
                    if (!calm && $urandom_range(0, 5) == 0)
                        src_gap = $urandom_range(1, 9);
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    task automatic check_result();
        hist_result_t e;
        if (result_due_q.size() == 0)
        begin
            $error("result with nothing pending: tdata %h tuser %b", m_tdata, m_tuser);
            fail_count++;
        end
        else
        begin
            e = result_due_q.pop_front();
            results_checked++;
            check_field("counted", {31'd0, e.counted}, {31'd0, m_tuser});
            check_field("kmer_code", {16'd0, e.code}, {16'd0, m_tdata[15:0]});
            check_field("count", e.cnt, m_tdata[47:16]);
            check_field("total_counted", e.total, m_tdata[79:48]);
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
                check_result();
            if (sink_stall != 0)
            begin
                sink_stall--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if (!calm && $urandom_range(0, 7) == 0)
                    sink_stall = $urandom_range(1, 9);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule
